/* hw/rtl/rprd_pkg.sv */
// ----------------------------------------------------------------------------
// rprd_pkg
// Shared types, widths and helpers for the random permutation ring draw block.
// ----------------------------------------------------------------------------
package rprd_pkg;

    localparam int MAX_ELEMENTS = 32;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int REM_W        = $clog2(2 * MAX_ELEMENTS);
    localparam int CFG_W        = 6;
    localparam int RND_W        = 16;
    localparam int ELEM_W       = 6;
    localparam int POS_W        = 5;
    localparam int BITCNT_W     = $clog2(RND_W + 1);

    localparam logic [CFG_W-1:0] COUNT_RESET = CFG_W'(25);

    typedef struct packed {
        logic [RND_W-1:0] random_value;
        logic             restart;
    } req_t;

    typedef struct packed {
        logic [ELEM_W-1:0] element;
        logic [POS_W-1:0]  position;
        logic              last_of_permutation;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic start_div;
        logic load_steps;
        logic walk_step;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic steps_zero;
        logic out_free;
    } sts_t;

    // raw count saturated to 2..MAX_ELEMENTS
    function automatic logic [CNT_W-1:0] eff_count(input logic [CFG_W-1:0] raw);
        if (int'(raw) < 2)
            return CNT_W'(2);
        else if (int'(raw) > MAX_ELEMENTS)
            return CNT_W'(MAX_ELEMENTS);
        else
            return CNT_W'(raw);
    endfunction

    // link of a slot in the freshly built ring
    function automatic logic [IDX_W-1:0] reset_link(input logic [IDX_W-1:0] idx,
                                                     input logic [CNT_W-1:0] k);
        logic [CNT_W:0] nxt;
        nxt = (CNT_W+1)'(idx) + (CNT_W+1)'(1);
        if (nxt < (CNT_W+1)'(k))
            return IDX_W'(nxt);
        else
            return IDX_W'(0);
    endfunction

endpackage

/* hw/rtl/rprd_mod.sv */
// ----------------------------------------------------------------------------
// rprd_mod
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module rprd_mod (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [rprd_pkg::RND_W-1:0] dividend,
    input  logic [rprd_pkg::CNT_W-1:0] divisor,
    output logic                       done,
    output logic [rprd_pkg::IDX_W-1:0] remainder
);
    import rprd_pkg::*;

    logic                busy_reg, busy_next;
    logic [BITCNT_W-1:0] cnt_reg, cnt_next;
    logic [RND_W-1:0]    dvd_reg, dvd_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]    dsr_reg, dsr_next;
    logic [REM_W-1:0]    trial;

    assign trial = {rem_reg[REM_W-2:0], dvd_reg[RND_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = BITCNT_W'(RND_W);
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[RND_W-2:0], 1'b0};
            if (trial >= REM_W'(dsr_reg))
                rem_next = trial - REM_W'(dsr_reg);
            else
                rem_next = trial;
            cnt_next = cnt_reg - BITCNT_W'(1);
            if (cnt_reg == BITCNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done      = !busy_reg;
    assign remainder = IDX_W'(rem_reg);

endmodule

/* hw/rtl/rprd_dpath.sv */
// ----------------------------------------------------------------------------
// rprd_dpath
// Link table, ring pointers, draw counter, step counter and result register.
// ----------------------------------------------------------------------------
module rprd_dpath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rprd_pkg::cmd_t             cmd,
    output rprd_pkg::sts_t             sts,
    input  rprd_pkg::req_t             in_data,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [rprd_pkg::CFG_W-1:0] cfg_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output rprd_pkg::rsp_t             out_data
);
    import rprd_pkg::*;

    logic [CFG_W-1:0]        count_reg;
    logic [IDX_W-1:0]        table_reg [MAX_ELEMENTS];
    logic [MAX_ELEMENTS-1:0] valid_reg;
    logic [IDX_W-1:0]        cur_reg, prev_reg;
    logic [CNT_W-1:0]        drawn_reg;
    logic [RND_W-1:0]        rnd_reg;
    logic [IDX_W-1:0]        steps_reg;
    logic                    out_valid_reg;
    rsp_t                    out_data_reg;

    logic [CNT_W-1:0]        k;
    logic [CNT_W-1:0]        k_new;
    logic [CNT_W-1:0]        drawn_inc;
    logic [IDX_W-1:0]        link_cur;
    logic                    cfg_wr;
    logic                    need_rebuild;
    logic                    div_done;
    logic [IDX_W-1:0]        remainder;
    logic                    out_free;

    assign k            = eff_count(count_reg);
    assign k_new        = eff_count(cfg_data);
    assign drawn_inc    = drawn_reg + CNT_W'(1);
    assign cfg_wr       = cfg_valid && cfg_ready;
    assign need_rebuild = in_data.restart || (drawn_reg >= k);
    assign link_cur     = valid_reg[cur_reg] ? table_reg[cur_reg] : reset_link(cur_reg, k);
    assign out_free     = !out_valid_reg || !out_stall;

    rprd_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.start_div),
        .dividend  (rnd_reg),
        .divisor   (k - drawn_reg),
        .done      (div_done),
        .remainder (remainder)
    );

    // control and ring state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= COUNT_RESET;
            valid_reg     <= '0;
            cur_reg       <= '0;
            prev_reg      <= IDX_W'(eff_count(COUNT_RESET) - CNT_W'(1));
            drawn_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (cfg_wr)
            begin
                count_reg <= cfg_data;
                valid_reg <= '0;
                cur_reg   <= '0;
                prev_reg  <= IDX_W'(k_new - CNT_W'(1));
                drawn_reg <= '0;
            end
            else if (cmd.load_item)
            begin
                if (need_rebuild)
                begin
                    valid_reg <= '0;
                    cur_reg   <= '0;
                    prev_reg  <= IDX_W'(k - CNT_W'(1));
                    drawn_reg <= '0;
                end
            end
            else if (cmd.walk_step)
            begin
                prev_reg <= cur_reg;
                cur_reg  <= link_cur;
            end
            else if (cmd.finish)
            begin
                if (drawn_inc >= k)
                begin
                    // permutation complete: fresh ring
                    valid_reg <= '0;
                    cur_reg   <= '0;
                    prev_reg  <= IDX_W'(k - CNT_W'(1));
                    drawn_reg <= '0;
                end
                else
                begin
                    valid_reg[prev_reg] <= 1'b1;
                    cur_reg             <= link_cur;
                    drawn_reg           <= drawn_inc;
                end
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
            rnd_reg <= in_data.random_value;
        if (cmd.load_steps)
            steps_reg <= remainder;
        else if (cmd.walk_step)
            steps_reg <= steps_reg - IDX_W'(1);
        if (cmd.finish)
        begin
            table_reg[prev_reg]              <= link_cur;
            out_data_reg.element             <= ELEM_W'(CNT_W'(cur_reg) + CNT_W'(1));
            out_data_reg.position            <= POS_W'(drawn_reg);
            out_data_reg.last_of_permutation <= (drawn_inc == k);
        end
    end

    assign sts.div_done   = div_done;
    assign sts.steps_zero = (steps_reg == '0);
    assign sts.out_free   = out_free;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* hw/rtl/rprd_ctrl.sv */
// ----------------------------------------------------------------------------
// rprd_ctrl
// Sequencer for one draw: take request, reduce, walk the ring, emit and unlink.
// ----------------------------------------------------------------------------
module rprd_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output rprd_pkg::cmd_t cmd,
    input  rprd_pkg::sts_t sts
);
    import rprd_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_PREP = 6'b000010,
        ST_DIV  = 6'b000100,
        ST_WALK = 6'b001000,
        ST_EMIT = 6'b010000,
        ST_WAIT = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.start_div = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.load_steps = 1'b1;
                    state_next     = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (sts.steps_zero)
                    state_next = ST_EMIT;
                else
                    cmd.walk_step = 1'b1;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                    state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

/* hw/rtl/random_permutation_ring_draw.sv */
// ----------------------------------------------------------------------------
// random_permutation_ring_draw
// Draws a random permutation of 1..K from a circular linked ring of the
// elements still undrawn, one element per request.
// ----------------------------------------------------------------------------
//
//  channel   handshake           payload   direction
//  in        in_valid/in_stall   req_t     random value and restart flag in
//  out       out_valid/out_stall rsp_t     element, position, last flag out
//  cfg       cfg_valid/cfg_ready 6 bits    count_in_use write
//
//  a request is taken, reduced by the bit-serial remainder to S = random_value
//  mod (K - drawn), the number of links walked (at most K-1), walked one link
//  per cycle over the link table, then emitted and unlinked; the next request
//  is accepted only after the result is in the output register
//  reset clears the ring to its in-order form for K = 25
//  in_stall is high from accept until the result is written to the output
//  register; a held result holds the final emit and unlink step, and the input stays stalled
//
module random_permutation_ring_draw (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  rprd_pkg::req_t             in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output rprd_pkg::rsp_t             out_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [rprd_pkg::CFG_W-1:0] cfg_data
);
    import rprd_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // writes must arrive only while idle, which the block does not enforce; the register port is always open
    assign cfg_ready = 1'b1;

    // sequencer: one request at a time through reduce, walk, emit
    rprd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .sts      (sts)
    );

    // ring storage, remainder unit and result register
    rprd_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ring-based permutation draw. A behavioral model
// of the link ring predicts every draw at request accept; a monitor compares
// each returned element, position and last flag against the oldest prediction
// while both channels idle and stall at random across several count settings.
// ----------------------------------------------------------------------------
module tb;

    import rprd_pkg::*;

    localparam int CLK_HALF_NS      = 1;
    localparam int RESET_CYCLES     = 10;
    // quiet margin after the last result before a count write
    localparam int SETTLE_CYCLES    = 60;
    localparam int LIMIT_NS         = 5_000_000;
    localparam int REPORT_LIMIT     = 10;
    localparam int HOLD_OFF_CYCLES  = 400;
    localparam int BURST_DRAWS      = 12;
    localparam int CHUNKS_PER_PHASE = 5;
    localparam int DRAWS_PER_CHUNK  = 95;
    localparam int RESTART_PCT      = 3;

    // dut ports; the inputs are driven to known values from time zero
    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    req_t             in_data   = '0;
    logic             out_stall = 1'b0;
    logic             cfg_valid = 1'b0;
    logic [CFG_W-1:0] cfg_data  = '0;
    logic             in_stall;
    logic             out_valid;
    rsp_t             out_data;
    logic             cfg_ready;

    // idling knobs, percent of cycles
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    // long receiver hold-off, counted down by the monitor
    int unsigned hold_left      = 0;

    // run statistics
    int unsigned draws_sent     = 0;
    int unsigned results_seen   = 0;
    int unsigned perms_done     = 0;
    int unsigned count_writes   = 0;
    int unsigned mismatch_count = 0;

    // predicted draws waiting for their result
    rsp_t draw_expect_q[$];

    // model of the undrawn ring
    logic [CFG_W-1:0] count_raw;
    logic [IDX_W-1:0] ring_next [MAX_ELEMENTS];
    logic [IDX_W-1:0] walk_head;
    logic [IDX_W-1:0] walk_tail;
    int unsigned      drawn_so_far;

    random_permutation_ring_draw dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #CLK_HALF_NS clk = ~clk;
    end

    // hard stop in case a handshake never completes
    initial
    begin
        #LIMIT_NS;
        $display("timeout: %0d requests sent, %0d results seen, %0d pending",
                 draws_sent, results_seen, draw_expect_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------------
    // ring model
    // ------------------------------------------------------------------------

    // configured count clamped into 2..MAX_ELEMENTS
    function automatic int unsigned ring_size();
        int unsigned k;
        k = count_raw;
        if (k < 2)
            k = 2;
        else if (k > MAX_ELEMENTS)
            k = MAX_ELEMENTS;
        return k;
    endfunction

    // ring in order, last live slot back to slot zero, spare slots at zero
    function automatic void ring_rebuild();
        int unsigned k;
        int          i;
        k = ring_size();
        for (i = 0; i < MAX_ELEMENTS; i++)
            ring_next[i] = (i + 1 < k) ? IDX_W'(i + 1) : '0;
        walk_head    = '0;
        walk_tail    = IDX_W'(k - 1);
        drawn_so_far = 0;
    endfunction

    // walk random_value mod remaining links, report the landing slot, unlink it
    function automatic rsp_t draw_predict(input logic [RND_W-1:0] rnd,
                                          input logic             restart);
        int unsigned      k;
        int unsigned      hops;
        logic [IDX_W-1:0] cur;
        logic [IDX_W-1:0] prv;
        rsp_t             res;
        k = ring_size();
        // a stale count starts a fresh permutation just like restart
        if (restart || drawn_so_far >= k)
            ring_rebuild();
        hops = int'(rnd) % (k - drawn_so_far);
        cur  = walk_head;
        prv  = walk_tail;
        repeat (hops)
        begin
            prv = cur;
            cur = ring_next[cur];
        end
        res.element             = ELEM_W'(int'(cur) + 1);
        res.position            = POS_W'(drawn_so_far);
        res.last_of_permutation = (drawn_so_far + 1 == k);
        ring_next[prv] = ring_next[cur];
        walk_head      = ring_next[prv];
        walk_tail      = prv;
        drawn_so_far++;
        if (drawn_so_far >= k)
            ring_rebuild();
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // result monitor and receiver stall generator
    // ------------------------------------------------------------------------

    function automatic void flag_mismatch(input string what);
        if (mismatch_count < REPORT_LIMIT)
            $display("mismatch at result %0d: %s", results_seen, what);
        mismatch_count++;
    endfunction

    initial
    begin : result_monitor
        rsp_t        want;
        int unsigned run_left;
        logic        stall_next;
        run_left = 0;
        forever
        begin
            @(posedge clk);
            // a result moves when valid is up and we are not stalling
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (out_data.last_of_permutation)
                    perms_done++;
                if (draw_expect_q.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected result element %0d position %0d",
                                            out_data.element, out_data.position));
                end
                else
                begin
                    want = draw_expect_q.pop_front();
                    if (out_data.element !== want.element)
                        flag_mismatch($sformatf("element expected %0d, got %0d",
                                                want.element, out_data.element));
                    if (out_data.position !== want.position)
                        flag_mismatch($sformatf("position expected %0d, got %0d",
                                                want.position, out_data.position));
                    if (out_data.last_of_permutation !== want.last_of_permutation)
                        flag_mismatch($sformatf("last flag expected %0b, got %0b",
                                                want.last_of_permutation,
                                                out_data.last_of_permutation));
                end
            end
            // long hold-off first, then random stall runs of mixed length
            if (hold_left > 0)
            begin
                hold_left--;
                stall_next = 1'b1;
            end
            else if (run_left > 0)
            begin
                run_left--;
                stall_next = 1'b1;
            end
            else if (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct)
            begin
                run_left   = ($urandom_range(15) == 0) ? $urandom_range(20, 80)
                                                       : $urandom_range(0, 7);
                stall_next = 1'b1;
            end
            else
            begin
                stall_next = 1'b0;
            end
            out_stall <= stall_next;
        end
    end

    // ------------------------------------------------------------------------
    // shared drivers
    // ------------------------------------------------------------------------

    // offer one request, leave valid high so a following request can go
    // back to back; the prediction is made at the accepting edge
    task automatic send_draw(input logic [RND_W-1:0] rnd, input logic restart);
        int unsigned gap;
        req_t        item;
        gap = 0;
        if (send_idle_pct != 0)
        begin
            while ($urandom_range(99) < send_idle_pct)
                gap++;
            // now and then a gap long enough to land anywhere in a walk
            if ($urandom_range(7) == 0)
                gap += $urandom_range(10, 60);
        end
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.random_value = rnd;
        item.restart      = restart;
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (in_stall);
        draw_expect_q.push_back(draw_predict(rnd, restart));
        draws_sent++;
    endtask

    // stop offering, wait for every predicted result, then a quiet margin
    task automatic drain_results();
        in_valid <= 1'b0;
        while (draw_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // count writes happen only with the block idle; each one rebuilds the ring
    task automatic write_count(input logic [CFG_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        count_raw = value;
        ring_rebuild();
        count_writes++;
    endtask

    // mostly full-range values, some small ones and the two extremes
    function automatic logic [RND_W-1:0] pick_random_value();
        case ($urandom_range(19))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return RND_W'($urandom_range(0, 40));
            default: return RND_W'($urandom());
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // default count after reset, with zero, all-ones, one and 24 as values
    task automatic test_reset_ring();
        send_draw('0, 1'b0);
        send_draw('1, 1'b0);
        send_draw(RND_W'(1), 1'b0);
        send_draw(RND_W'(24), 1'b0);
    endtask

    // restart flag throws away a partly drawn permutation
    task automatic test_restart();
        send_draw(RND_W'(16'h0005), 1'b0);
        send_draw(RND_W'(16'h8000), 1'b1);
        send_draw(RND_W'(16'h7fff), 1'b1);
    endtask

    // counts below, at and above the legal range saturate
    task automatic test_count_extremes();
        write_count(CFG_W'(0));
        send_draw(RND_W'(16'h0001), 1'b0);
        send_draw(RND_W'(16'hffff), 1'b0);
        send_draw(RND_W'(16'h0000), 1'b0);
        write_count(CFG_W'(1));
        send_draw(RND_W'(16'h0003), 1'b0);
        send_draw(RND_W'(16'h0002), 1'b0);
        write_count(CFG_W'(63));
        send_draw(RND_W'(16'hffff), 1'b0);
        send_draw(RND_W'(16'h001f), 1'b1);
        write_count(CFG_W'(33));
        send_draw(RND_W'(16'haaaa), 1'b0);
        write_count(CFG_W'(MAX_ELEMENTS));
        send_draw(RND_W'(16'h5555), 1'b0);
        write_count(CFG_W'(2));
        send_draw(RND_W'(16'h0001), 1'b0);
    endtask

    // a count write in the middle of a permutation starts a fresh ring
    task automatic test_write_mid_permutation();
        write_count(CFG_W'(5));
        send_draw(RND_W'(16'h0003), 1'b0);
        send_draw(RND_W'(16'h0102), 1'b0);
        write_count(CFG_W'(3));
        send_draw(RND_W'(16'h0002), 1'b0);
        send_draw(RND_W'(16'h0001), 1'b0);
        send_draw(RND_W'(16'hfffe), 1'b0);
    endtask

    // receiver holds off long while requests keep coming, so the output
    // register and then the input back up; then the sender waits it out
    task automatic test_output_backpressure();
        int n;
        drain_results();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = HOLD_OFF_CYCLES;
        for (n = 0; n < BURST_DRAWS; n++)
            send_draw(pick_random_value(), 1'b0);
        drain_results();
    endtask

    // random requests over a handful of counts under one idling mix
    task automatic test_random_phase(input int unsigned send_pct,
                                     input int unsigned recv_pct);
        int               chunk;
        int               n;
        logic [CFG_W-1:0] count_pick;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (chunk = 0; chunk < CHUNKS_PER_PHASE; chunk++)
        begin
            case ($urandom_range(9))
                0:       count_pick = CFG_W'(2);
                1:       count_pick = CFG_W'(MAX_ELEMENTS);
                2:       count_pick = CFG_W'($urandom_range(0, 1));
                3:       count_pick = CFG_W'($urandom_range(MAX_ELEMENTS + 1, 63));
                default: count_pick = CFG_W'($urandom_range(2, MAX_ELEMENTS));
            endcase
            write_count(count_pick);
            // mostly whole permutations, a few restarts cut them short
            for (n = 0; n < DRAWS_PER_CHUNK; n++)
                send_draw(pick_random_value(), $urandom_range(99) < RESTART_PCT);
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin
        // model starts where reset leaves the block
        count_raw = COUNT_RESET;
        ring_rebuild();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_ring();
        test_restart();
        test_count_extremes();
        test_write_mid_permutation();
        test_output_backpressure();
        test_random_phase(0, 0);
        test_random_phase(78, 0);
        test_random_phase(0, 78);
        test_random_phase(29, 29);

        drain_results();

        $display("covered %0d draw requests, %0d results, %0d full permutations",
                 draws_sent, results_seen, perms_done);
        $display("across %0d count writes incl. saturated counts, %0d mismatches",
                 count_writes, mismatch_count);
        if (mismatch_count == 0 && draw_expect_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
